// ===== hw/rtl/dlf_pkg.sv =====
package dlf_pkg;

  // Byte sources for the transmit register.
  typedef enum logic [2:0] {
    SEL_TABLE,
    SEL_LETTER,
    SEL_MSG,
    SEL_HEX_HI,
    SEL_HEX_LO
  } byte_sel_e;

  // Index into the table of fixed frame bytes.
  typedef logic [3:0] tidx_t;

  // Positions in the fixed frame byte table.
  localparam tidx_t TIDX_START    = 4'd0;   // 0x0D opening the write frame
  localparam tidx_t TIDX_CMD      = 4'd1;   // first of 'O','0','0','0','1'
  localparam tidx_t TIDX_WR_END   = 4'd6;   // 0x0A closing the write frame
  localparam tidx_t TIDX_EXEC_END = 4'd15;  // 0x0A closing the execute frame

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take_letter;
    logic      store_byte;
    logic      rd_first;
    logic      rd_en;
    logic      rd_next;
    logic      load_out;
    byte_sel_e sel;
    tidx_t     tidx;
    logic      last;
  } dlf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic line_end;
    logic msg_empty;
    logic msg_last;
  } dlf_stat_t;

endpackage

// ===== hw/rtl/dlf_datapath.sv =====
module dlf_datapath #(
  parameter int MAX_MESSAGE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_ready_i,
  input  dlf_pkg::dlf_cmd_t cmd_i,
  output dlf_pkg::dlf_stat_t stat_o,
  output logic              out_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              last_byte_o
);

  localparam int CntW  = $clog2(MAX_MESSAGE + 1);
  localparam int AddrW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;

  localparam logic [7:0] LINE_END = 8'h25;
  // Header bytes 'O','0','0','0','1' plus the starting value 13, folded mod 256.
  localparam logic [7:0] CHK_OFFSET = 8'((13 + 8'h4F + 3 * 8'h30 + 8'h31) % 256);

  function automatic logic [7:0] frame_table(dlf_pkg::tidx_t idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h0D;
      4'd1:    b = 8'h4F;
      4'd2:    b = 8'h30;
      4'd3:    b = 8'h30;
      4'd4:    b = 8'h30;
      4'd5:    b = 8'h31;
      4'd6:    b = 8'h0A;
      4'd7:    b = 8'h0D;
      4'd8:    b = 8'h5A;
      4'd9:    b = 8'h44;
      4'd10:   b = 8'h30;
      4'd11:   b = 8'h30;
      4'd12:   b = 8'h31;
      4'd13:   b = 8'h33;
      4'd14:   b = 8'h43;
      4'd15:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] b;
    if (v < 4'd10) begin
      b = 8'h30 + {4'd0, v};
    end else begin
      b = 8'h41 + {4'd0, v - 4'd10};
    end
    return b;
  endfunction

  logic [7:0]      mem_q [MAX_MESSAGE];
  logic [7:0]      rd_data_q;
  logic [7:0]      letter_q;
  logic [7:0]      sum_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] rd_idx_q;
  logic            out_valid_q;
  logic [7:0]      tx_q;
  logic            last_q;
  logic [7:0]      chk;
  logic [7:0]      out_byte;
  logic            full;

  assign full = (count_q == CntW'(MAX_MESSAGE));
  assign chk  = sum_q + CHK_OFFSET;

  always_comb begin
    case (cmd_i.sel)
      dlf_pkg::SEL_LETTER: out_byte = letter_q;
      dlf_pkg::SEL_MSG:    out_byte = rd_data_q;
      dlf_pkg::SEL_HEX_HI: out_byte = hex_char(chk[7:4]);
      dlf_pkg::SEL_HEX_LO: out_byte = hex_char(chk[3:0]);
      default:             out_byte = frame_table(cmd_i.tidx);
    endcase
  end

  // Message store: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte && !full) begin
      mem_q[count_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q    <= 8'd0;
      sum_q       <= 8'd0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_letter) begin
        letter_q <= rx_byte_i;
        sum_q    <= rx_byte_i;
        count_q  <= '0;
      end else if (cmd_i.store_byte && !full) begin
        sum_q   <= sum_q + rx_byte_i;
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.rd_first) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_next) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      tx_q   <= out_byte;
      last_q <= cmd_i.last;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.line_end  = (rx_byte_i == LINE_END);
  assign stat_o.msg_empty = (count_q == '0);
  assign stat_o.msg_last  = (CntW'(rd_idx_q + CntW'(1)) == count_q);

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;

endmodule

// ===== hw/rtl/dlf_controller.sv =====
module dlf_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dlf_pkg::dlf_stat_t stat_i,
  output dlf_pkg::dlf_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_LETTER,
    S_TEXT,
    S_HEAD,
    S_MSG_RD,
    S_MSG_LD,
    S_TAIL
  } state_e;

  // Head covers 0x0D, the letter and the command; tail covers the checksum,
  // 0x0A and the whole execute frame.
  localparam logic [3:0] HEAD_LAST = 4'd6;
  localparam logic [3:0] TAIL_LAST = 4'd11;
  localparam logic [3:0] TAIL_TBL  = 4'd4;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       accept;

  assign in_ready_o = (state_q == S_LETTER) || (state_q == S_TEXT);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_LETTER: begin
        if (accept) begin
          cmd_o.take_letter = 1'b1;
          state_d           = S_TEXT;
        end
      end
      S_TEXT: begin
        if (accept) begin
          if (stat_i.line_end) begin
            state_d = S_HEAD;
            step_d  = 4'd0;
          end else begin
            cmd_o.store_byte = 1'b1;
          end
        end
      end
      S_HEAD: begin
        if (step_q == 4'd0) begin
          cmd_o.tidx = dlf_pkg::TIDX_START;
        end else if (step_q == 4'd1) begin
          cmd_o.sel = dlf_pkg::SEL_LETTER;
        end else begin
          cmd_o.tidx = dlf_pkg::TIDX_CMD + (step_q - 4'd2);
        end
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (step_q == HEAD_LAST) begin
            step_d = 4'd0;
            if (stat_i.msg_empty) begin
              state_d = S_TAIL;
            end else begin
              cmd_o.rd_first = 1'b1;
              state_d        = S_MSG_RD;
            end
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      S_MSG_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_MSG_LD;
      end
      S_MSG_LD: begin
        cmd_o.sel = dlf_pkg::SEL_MSG;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.msg_last) begin
            state_d = S_TAIL;
            step_d  = 4'd0;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_MSG_RD;
          end
        end
      end
      S_TAIL: begin
        if (step_q == 4'd0) begin
          cmd_o.sel = dlf_pkg::SEL_HEX_HI;
        end else if (step_q == 4'd1) begin
          cmd_o.sel = dlf_pkg::SEL_HEX_LO;
        end else begin
          cmd_o.tidx = step_q + TAIL_TBL;
        end
        cmd_o.last = (step_q == TAIL_LAST);
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (step_q == TAIL_LAST) begin
            state_d = S_LETTER;
            step_d  = 4'd0;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = S_LETTER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LETTER;
      step_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== hw/rtl/display_line_framer.sv =====
// Display line framer. Received bytes arrive as requests on the input channel,
// one byte per request: the first byte of a line is its memory letter, every
// later byte other than '%' is message text, of which the first MAX_MESSAGE
// bytes are kept and the rest dropped, and a '%' ends the line. Ending a line
// streams a write frame (0x0D, letter, "O0001", message, two uppercase hex
// checksum characters, 0x0A) followed by the execute frame "\rZD0013C\n" on the
// output channel, with last_byte_o high on the closing 0x0A of the execute
// frame. While a line is being received, each letter, text or '%' byte is
// taken as soon as it is offered; after a '%' the input is held off until the
// last byte of the execute frame has been loaded into the output register.
// Header and trailer bytes go out one per cycle while the output is not
// stalled, whereas each message byte must first be read from the message
// memory, which has a single registered read port. The final byte of the
// frames may still be waiting in the output register while the next line's
// letter is accepted. There is no clearing pass after reset; the message
// memory is only read up to its fill count.
module display_line_framer #(
  parameter int MAX_MESSAGE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);

  // The controller sequences the frames; the datapath owns the message store,
  // the checksum and the transmit register.
  dlf_pkg::dlf_cmd_t  cmd;
  dlf_pkg::dlf_stat_t stat;

  dlf_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dlf_datapath #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ===== hw/rtl/dlf_checker.sv =====
module dlf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] tx_byte_o,
  input logic       last_byte_o
);

  // A stalled output request keeps its byte.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o) && $stable(last_byte_o))
    else $error("output request changed while stalled");

  // The closing byte of the execute frame is always a line feed.
  a_last_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> tx_byte_o == 8'h0A)
    else $error("last byte is not a line feed");

  // Input is only taken mid-frame-free: a pending output then is the last byte.
  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_ready_o |-> last_byte_o)
    else $error("input accepted while a frame is still streaming");

  // The last byte is never followed directly by another last byte.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_byte_o |=> !(out_valid_o && last_byte_o))
    else $error("last byte repeated directly after the last byte");

endmodule

bind display_line_framer dlf_checker u_dlf_checker (.*);

// ===== verif/tb_display_line_framer.sv =====
module tb_display_line_framer;

  localparam int MAX_MESSAGE = 32;

  // Fixed frame bytes.
  localparam logic [7:0]  FRAME_START = 8'h0D;
  localparam logic [7:0]  FRAME_END   = 8'h0A;
  localparam logic [7:0]  LINE_END    = 8'h25;
  localparam logic [39:0] CMD_TAIL    = "O0001";
  localparam logic [55:0] EXEC_BODY   = "ZD0013C";
  localparam logic [7:0]  CHECK_BASE  = 8'd13;

  // Length of the random part, the idle limit, the quiet time at the end and the report cap.
  localparam int RANDOM_ITEMS   = 385;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int MAX_REPORTS    = 50;

  // One pending request: the byte, the idle cycles before it and whether
  // the sender must first wait for every frame byte to come out.
  typedef struct {
    logic [7:0] data;
    int         gap;
    bit         drain;
  } rx_item_t;

  // One expected transmit byte.
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } tx_beat_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] tx_byte;
  logic       last_byte;

  rx_item_t   rx_pending[$];
  tx_beat_t   frame_bytes_due[$];
  int         errors = 0;
  int         gap_done = 0;
  int         stall_left = 0;
  logic [9:0] mon_cycle = '0;
  int         idle_cycles = 0;

  // Shadow of the framer's line state.
  bit         want_letter = 1'b1;
  logic [7:0] line_letter = 8'h00;
  logic [7:0] line_text [MAX_MESSAGE];
  int         stored = 0;
  logic [7:0] line_sum = 8'h00;

  display_line_framer #(
    .MAX_MESSAGE(MAX_MESSAGE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .tx_byte_o  (tx_byte),
    .last_byte_o(last_byte)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      g = 0;
    end else if (r < 90) begin
      g = $urandom_range(1, 3);
    end else if (r < 98) begin
      g = $urandom_range(4, 10);
    end else begin
      g = $urandom_range(20, 60);
    end
    return g;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + v) : (8'h41 + (v - 4'd10));
  endfunction

  function automatic void due(input logic [7:0] b, input logic last);
    tx_beat_t beat;
    beat.tx   = b;
    beat.last = last;
    frame_bytes_due.push_back(beat);
  endfunction

  // Advances the shadow line state by one received byte. A '%' that ends
  // a line queues the whole write frame and then the execute frame.
  function automatic void predict_frames(input logic [7:0] b);
    logic [7:0] csum;
    int i;
    if (want_letter) begin
      // Any byte may be the letter, a '%' included.
      line_letter = b;
      stored      = 0;
      line_sum    = b;
      want_letter = 1'b0;
    end else if (b != LINE_END) begin
      // Text beyond the store is dropped and left out of the checksum.
      if (stored < MAX_MESSAGE) begin
        line_text[stored] = b;
        stored++;
        line_sum += b;
      end
    end else begin
      csum = line_sum + CHECK_BASE;
      for (i = 0; i < 5; i++) csum += CMD_TAIL[8*(4-i) +: 8];
      due(FRAME_START, 1'b0);
      due(line_letter, 1'b0);
      for (i = 0; i < 5; i++) due(CMD_TAIL[8*(4-i) +: 8], 1'b0);
      for (i = 0; i < stored; i++) due(line_text[i], 1'b0);
      due(hex_char(csum[7:4]), 1'b0);
      due(hex_char(csum[3:0]), 1'b0);
      due(FRAME_END, 1'b0);
      due(FRAME_START, 1'b0);
      for (i = 0; i < 7; i++) due(EXEC_BODY[8*(6-i) +: 8], 1'b0);
      due(FRAME_END, 1'b1);
      want_letter = 1'b1;
      stored      = 0;
      line_sum    = 8'h00;
    end
  endfunction

  function automatic void add(input logic [7:0] d, input bit drain, input bit calm);
    rx_item_t it;
    it.data  = d;
    it.gap   = calm ? 0 : pick_gap();
    it.drain = drain;
    rx_pending.push_back(it);
  endfunction

  // Compares one accepted transmit byte with the oldest expectation.
  function automatic void check_beat(input logic [7:0] b, input logic last);
    tx_beat_t want;
    if (frame_bytes_due.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) $error("tx_byte: expected none, actual %02h", b);
    end else begin
      want = frame_bytes_due.pop_front();
      if (b !== want.tx) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $error("tx_byte: expected %02h, actual %02h", want.tx, b);
        end
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $error("last_byte: expected %0b, actual %0b", want.last, last);
        end
      end
    end
  endfunction

  // Driver. A request stays up, unchanged, until the framer takes it. The
  // expected frames are queued as soon as a '%' is presented, because the
  // framer starts streaming them once it has taken that request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
      gap_done <= 0;
    end else if (in_valid && !in_ready) begin
      // Request still waiting to be taken.
    end else if (rx_pending.size() == 0) begin
      in_valid <= 1'b0;
    end else if (rx_pending[0].drain && frame_bytes_due.size() != 0) begin
      // Hold off until every frame byte of earlier lines has come out.
      in_valid <= 1'b0;
    end else if (gap_done < rx_pending[0].gap) begin
      in_valid <= 1'b0;
      gap_done <= gap_done + 1;
    end else begin
      rx_byte  <= rx_pending[0].data;
      in_valid <= 1'b1;
      predict_frames(rx_pending[0].data);
      void'(rx_pending.pop_front());
      gap_done <= 0;
    end
  end

  // Monitor. It checks each accepted byte and stalls the framer at random, but
  // starts no new stall in the first quarter of each pass of its cycle counter.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      mon_cycle  <= '0;
    end else begin
      mon_cycle <= mon_cycle + 10'd1;
      if (out_valid && out_ready) check_beat(tx_byte, last_byte);
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (mon_cycle[9:8] == 2'd0 || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("display_line_framer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int  n;
    int  len;
    int  r;
    int  i;
    bit  calm;
    bit  drain;
    logic [7:0] b;

    // A plain line with text.
    add("A", 1'b0, 1'b0);
    add("H", 1'b0, 1'b0);
    add("E", 1'b0, 1'b0);
    add("L", 1'b0, 1'b0);
    add("L", 1'b0, 1'b0);
    add("O", 1'b0, 1'b0);
    add(LINE_END, 1'b0, 1'b0);
    // An empty line, sent only once the previous frames are out.
    add("B", 1'b1, 1'b0);
    add(LINE_END, 1'b0, 1'b0);
    // A '%' as the letter.
    add(LINE_END, 1'b0, 1'b1);
    add("x", 1'b0, 1'b1);
    add(LINE_END, 1'b0, 1'b1);
    // Zero and all-ones text bytes, and frame bytes inside the text.
    add("C", 1'b0, 1'b0);
    add(8'h00, 1'b0, 1'b0);
    add(8'hFF, 1'b0, 1'b0);
    add(FRAME_START, 1'b0, 1'b0);
    add(FRAME_END, 1'b0, 1'b0);
    add(LINE_END, 1'b0, 1'b0);
    // Extreme letters.
    add(8'h00, 1'b0, 1'b0);
    add(LINE_END, 1'b0, 1'b0);
    add(8'hFF, 1'b0, 1'b0);
    add(LINE_END, 1'b0, 1'b0);

    // Random lines: mostly short, some around and beyond the store size.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm  = ($urandom_range(0, 4) == 0);
      drain = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(0, 8);
      end else if (r == 7) begin
        len = $urandom_range(30, 34);
      end else begin
        len = $urandom_range(35, 40);
      end
      add(8'($urandom_range(0, 255)), drain, calm);
      for (i = 0; i < len; i++) begin
        do b = 8'($urandom_range(0, 255)); while (b == LINE_END);
        add(b, 1'b0, calm);
      end
      add(LINE_END, 1'b0, calm);
      n += len + 2;
    end
    // A line left open at the end, which must produce nothing unless its second byte happens to be a '%'.
    add(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    add(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    add(8'h00, 1'b0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("display_line_framer: match");
    end else begin
      $display("display_line_framer: mismatch");
    end
    $finish;
  end

endmodule
